@@ sv/crc_pkg.sv @@
// crc_pkg: shared types, register codes, reset values and the hour window
// function of the climate relay controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package crc_pkg;

  localparam int CfgIndexWidth = 4;
  localparam int CfgDataWidth  = 10;

  localparam logic [CfgIndexWidth-1:0] REG_MODE_BITS     = 4'd0;
  localparam logic [CfgIndexWidth-1:0] REG_LIGHTS_WINDOW = 4'd1;
  localparam logic [CfgIndexWidth-1:0] REG_TEMP_WINDOW   = 4'd2;
  localparam logic [CfgIndexWidth-1:0] REG_HUMID_WINDOW  = 4'd3;
  localparam logic [CfgIndexWidth-1:0] REG_TEMP_TARGET   = 4'd4;
  localparam logic [CfgIndexWidth-1:0] REG_HUMID_TARGET  = 4'd5;
  localparam logic [CfgIndexWidth-1:0] REG_TEMP_BAND     = 4'd6;
  localparam logic [CfgIndexWidth-1:0] REG_HUMID_BAND    = 4'd7;

  localparam int MODE_TEMP_THERMO = 0;
  localparam int MODE_TEMP_COOL   = 1;
  localparam int MODE_HUMID_THERMO = 2;
  localparam int MODE_HUMID_LOWER = 3;

  localparam logic [4:0] HOURS_PER_DAY = 5'd24;

  localparam logic [5:0] TEMP_TARGET_RESET  = 6'd25;
  localparam logic [6:0] HUMID_TARGET_RESET = 7'd60;
  localparam logic [6:0] TEMP_BAND_RESET    = 7'd10;
  localparam logic [7:0] HUMID_BAND_RESET   = 8'd20;

  typedef struct packed {
    logic [4:0]         hour_now;
    logic signed [11:0] temp_reading;
    logic [9:0]         humid_reading;
    logic               sensor_fault;
  } sample_t;

  typedef struct packed {
    logic       lights_drive;
    logic       temp_drive;
    logic       humid_drive;
    logic [1:0] active_count;
    logic       any_changed;
  } status_t;

  typedef struct packed {
    logic [3:0] mode_bits;
    logic [9:0] lights_window;
    logic [9:0] temp_window;
    logic [9:0] humid_window;
    logic [5:0] temp_target;
    logic [6:0] humid_target;
    logic [6:0] temp_band;
    logic [7:0] humid_band;
  } cfg_t;

  typedef struct packed {
    logic lights;
    logic temp;
    logic humid;
  } relay_t;

  function automatic logic window_on(input logic [9:0] win, input logic [4:0] hour);
    logic [4:0] on_h;
    logic [4:0] off_h;
    logic       result;
    on_h  = win[4:0];
    off_h = win[9:5];
    if (on_h == off_h) begin
      result = 1'b0;
    end else if ((on_h == 5'd0 && off_h == HOURS_PER_DAY) ||
                 (on_h == HOURS_PER_DAY && off_h == 5'd0)) begin
      result = 1'b0;
    end else if (off_h > on_h) begin
      result = (hour >= on_h) && (hour < off_h);
    end else begin
      result = (hour >= on_h) || (hour < off_h);
    end
    return result;
  endfunction

endpackage

`default_nettype wire

@@ sv/crc_cfg_regs.sv @@
// crc_cfg_regs: configuration register file of the climate relay controller
// depends on crc_pkg
`timescale 1ns / 1ps
`default_nettype none

module crc_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [crc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [crc_pkg::CfgDataWidth-1:0]  cfg_data,
  output      crc_pkg::cfg_t                    cfg
);

  crc_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode_bits     <= '0;
      regs.lights_window <= '0;
      regs.temp_window   <= '0;
      regs.humid_window  <= '0;
      regs.temp_target   <= crc_pkg::TEMP_TARGET_RESET;
      regs.humid_target  <= crc_pkg::HUMID_TARGET_RESET;
      regs.temp_band     <= crc_pkg::TEMP_BAND_RESET;
      regs.humid_band    <= crc_pkg::HUMID_BAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        crc_pkg::REG_MODE_BITS:     regs.mode_bits     <= cfg_data[3:0];
        crc_pkg::REG_LIGHTS_WINDOW: regs.lights_window <= cfg_data[9:0];
        crc_pkg::REG_TEMP_WINDOW:   regs.temp_window   <= cfg_data[9:0];
        crc_pkg::REG_HUMID_WINDOW:  regs.humid_window  <= cfg_data[9:0];
        crc_pkg::REG_TEMP_TARGET:   regs.temp_target   <= cfg_data[5:0];
        crc_pkg::REG_HUMID_TARGET:  regs.humid_target  <= cfg_data[6:0];
        crc_pkg::REG_TEMP_BAND:     regs.temp_band     <= cfg_data[6:0];
        crc_pkg::REG_HUMID_BAND:    regs.humid_band    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/crc_relay_logic.sv @@
// crc_relay_logic: next relay states and result beat for one sample
// depends on crc_pkg (types, window_on)
`timescale 1ns / 1ps
`default_nettype none

module crc_relay_logic (
  input  wire crc_pkg::cfg_t    cfg,
  input  wire crc_pkg::sample_t sample,
  input  wire crc_pkg::relay_t  cur,
  output      crc_pkg::relay_t  nxt,
  output      crc_pkg::status_t status
);

  logic signed [12:0] temp_val;
  logic signed [12:0] humid_val;
  logic signed [12:0] temp_set;
  logic signed [12:0] humid_set;
  logic signed [12:0] temp_band;
  logic signed [12:0] humid_band;
  logic               t_on;
  logic               t_off;
  logic               h_on;
  logic               h_off;
  logic               t_hyst;
  logic               h_hyst;

  // setpoints times ten as shift and add
  always_comb begin
    temp_val   = 13'(sample.temp_reading);
    humid_val  = $signed({3'b000, sample.humid_reading});
    temp_set   = $signed({4'b0000, cfg.temp_target, 3'b000}) +
                 $signed({6'b000000, cfg.temp_target, 1'b0});
    humid_set  = $signed({3'b000, cfg.humid_target, 3'b000}) +
                 $signed({5'b00000, cfg.humid_target, 1'b0});
    temp_band  = $signed({6'b000000, cfg.temp_band});
    humid_band = $signed({5'b00000, cfg.humid_band});

    if (cfg.mode_bits[crc_pkg::MODE_TEMP_COOL]) begin
      t_on  = temp_val > temp_set;
      t_off = temp_val <= (temp_set - temp_band);
    end else begin
      t_on  = temp_val < temp_set;
      t_off = temp_val >= (temp_set + temp_band);
    end

    if (cfg.mode_bits[crc_pkg::MODE_HUMID_LOWER]) begin
      h_on  = humid_val > (humid_set + humid_band);
      h_off = humid_val < (humid_set - humid_band);
    end else begin
      h_on  = humid_val < humid_set;
      h_off = humid_val > (humid_set + humid_band);
    end

    // turn-on first, then turn-off wins
    t_hyst = (cur.temp || t_on) && !t_off;
    h_hyst = (cur.humid || h_on) && !h_off;

    nxt.lights = crc_pkg::window_on(cfg.lights_window, sample.hour_now);

    if (cfg.mode_bits[crc_pkg::MODE_TEMP_THERMO]) begin
      nxt.temp = t_hyst && !sample.sensor_fault;
    end else begin
      nxt.temp = crc_pkg::window_on(cfg.temp_window, sample.hour_now);
    end

    if (cfg.mode_bits[crc_pkg::MODE_HUMID_THERMO]) begin
      nxt.humid = h_hyst;
    end else begin
      nxt.humid = crc_pkg::window_on(cfg.humid_window, sample.hour_now);
    end

    status.lights_drive = nxt.lights;
    status.temp_drive   = nxt.temp;
    status.humid_drive  = nxt.humid;
    status.active_count = {1'b0, nxt.lights} + {1'b0, nxt.temp} + {1'b0, nxt.humid};
    status.any_changed  = nxt != cur;
  end

endmodule

`default_nettype wire

@@ sv/climate_relay_controller.sv @@
// climate_relay_controller: top level, input register, relay state and
// result register around one combinational pass
// depends on crc_pkg, crc_cfg_regs, crc_relay_logic
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+----------------------------
//   sample   | sample_valid / sample_stall | crc_pkg::sample_t
//   status   | status_valid / status_stall | crc_pkg::status_t
//   cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// one sample beat per cycle sustained while status is not stalled; a beat taken into
// the input register passes to the result register once that is free, then shows on status
// relay states update as the result register loads, so back-to-back samples
// see the state left by the one before
// rst clears relays, valids and configuration to their reset values
// a stalled status beat holds; sample_stall rises only while both registers are full
`timescale 1ns / 1ps
`default_nettype none

module climate_relay_controller (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              sample_valid,
  output      logic                              sample_stall,
  input  wire crc_pkg::sample_t                  sample,
  output      logic                              status_valid,
  input  wire logic                              status_stall,
  output      crc_pkg::status_t                  status,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [crc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [crc_pkg::CfgDataWidth-1:0]  cfg_data
);

  crc_pkg::cfg_t    cfg;
  crc_pkg::sample_t hold;
  logic             hold_valid;
  crc_pkg::relay_t  relay;
  crc_pkg::relay_t  relay_next;
  crc_pkg::status_t status_next;
  logic             out_free;
  logic             advance;
  logic             take;

  crc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  crc_relay_logic u_logic (
    .cfg    (cfg),
    .sample (hold),
    .cur    (relay),
    .nxt    (relay_next),
    .status (status_next)
  );

  assign out_free     = !status_valid || !status_stall;
  assign advance      = hold_valid && out_free;
  assign sample_stall = hold_valid && !out_free;
  assign take         = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      status_valid <= 1'b0;
      relay        <= '0;
    end else begin
      if (take) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        status_valid <= 1'b1;
        relay        <= relay_next;
      end else if (!status_stall) begin
        status_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold <= sample;
    end
    if (advance) begin
      status <= status_next;
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    status_valid |-> status.active_count ==
      2'($countones({status.lights_drive, status.temp_drive, status.humid_drive})))
    else $error("active_count disagrees with relay drives");

  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    advance |=> status.any_changed == (relay != $past(relay)))
    else $error("any_changed disagrees with relay state update");

  a_fault_forces_off: assert property (@(posedge clk) disable iff (rst)
    advance && hold.sensor_fault && cfg.mode_bits[crc_pkg::MODE_TEMP_THERMO]
      |=> !status.temp_drive && !relay.temp)
    else $error("sensor fault did not force temperature relay off");

  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !advance |=> hold_valid && $stable(hold))
    else $error("waiting sample lost from input register");

  a_relay_tracks_out: assert property (@(posedge clk) disable iff (rst)
    status_valid |-> relay == {status.lights_drive, status.temp_drive, status.humid_drive})
    else $error("relay state and last status beat disagree");

endmodule

`default_nettype wire

@@ tb/sv/climate_relay_controller_tb.sv @@
// climate_relay_controller_tb: self-checking bench for the relay controller,
// sample driver and status monitor around a cycle-free predictor of the relays
// depends on crc_pkg and climate_relay_controller
`timescale 1ns / 1ps

module climate_relay_controller_tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SHOW_LIMIT = 100;
  localparam logic [crc_pkg::CfgIndexWidth-1:0] REG_FIRST_UNUSED =
    crc_pkg::REG_HUMID_BAND + 4'd1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  crc_pkg::sample_t sample = '0;
  logic status_valid;
  logic status_stall = 1'b0;
  crc_pkg::status_t status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [crc_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [crc_pkg::CfgDataWidth-1:0] cfg_data = '0;

  crc_pkg::sample_t sample_queue[$];
  crc_pkg::status_t status_due[$];
  crc_pkg::cfg_t shadow_cfg = '{mode_bits: '0, lights_window: '0, temp_window: '0,
                                humid_window: '0,
                                temp_target: crc_pkg::TEMP_TARGET_RESET,
                                humid_target: crc_pkg::HUMID_TARGET_RESET,
                                temp_band: crc_pkg::TEMP_BAND_RESET,
                                humid_band: crc_pkg::HUMID_BAND_RESET};
  crc_pkg::relay_t relays = '0;
  logic calm = 1'b0;
  int errors = 0;
  int samples_taken = 0;
  int statuses_seen = 0;
  int settings_loaded = 0;
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  climate_relay_controller u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .status_valid (status_valid),
    .status_stall (status_stall),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  function automatic logic hour_in_window(logic [9:0] w, logic [4:0] hour);
    logic [4:0] on_h;
    logic [4:0] off_h;
    on_h = w[4:0];
    off_h = w[9:5];
    if (on_h == off_h) return 1'b0;
    if ((on_h == 5'd0 && off_h == crc_pkg::HOURS_PER_DAY) ||
        (on_h == crc_pkg::HOURS_PER_DAY && off_h == 5'd0))
      return 1'b0;
    if (off_h > on_h) return hour >= on_h && hour < off_h;
    return hour >= on_h || hour < off_h;
  endfunction

  function automatic logic settle(logic cur, logic turn_on, logic turn_off);
    logic nxt;
    nxt = cur;
    if (!nxt && turn_on) nxt = 1'b1;
    if (nxt && turn_off) nxt = 1'b0;
    return nxt;
  endfunction

  // advances the relay copy by one sample and returns the status it reports
  function automatic crc_pkg::status_t next_status(crc_pkg::sample_t s);
    crc_pkg::relay_t nx;
    crc_pkg::status_t r;
    int temp, humid, tset, hset, tband, hband;
    temp = int'(s.temp_reading);
    humid = int'(s.humid_reading);
    tset = int'(shadow_cfg.temp_target) * 10;
    hset = int'(shadow_cfg.humid_target) * 10;
    tband = int'(shadow_cfg.temp_band);
    hband = int'(shadow_cfg.humid_band);
    nx.lights = hour_in_window(shadow_cfg.lights_window, s.hour_now);
    if (shadow_cfg.mode_bits[crc_pkg::MODE_TEMP_THERMO]) begin
      if (s.sensor_fault) begin
        nx.temp = 1'b0;
      end else if (shadow_cfg.mode_bits[crc_pkg::MODE_TEMP_COOL]) begin
        nx.temp = settle(relays.temp, temp > tset, temp <= tset - tband);
      end else begin
        nx.temp = settle(relays.temp, temp < tset, temp >= tset + tband);
      end
    end else begin
      nx.temp = hour_in_window(shadow_cfg.temp_window, s.hour_now);
    end
    if (shadow_cfg.mode_bits[crc_pkg::MODE_HUMID_THERMO]) begin
      if (shadow_cfg.mode_bits[crc_pkg::MODE_HUMID_LOWER]) begin
        nx.humid = settle(relays.humid, humid > hset + hband, humid < hset - hband);
      end else begin
        nx.humid = settle(relays.humid, humid < hset, humid > hset + hband);
      end
    end else begin
      nx.humid = hour_in_window(shadow_cfg.humid_window, s.hour_now);
    end
    r.lights_drive = nx.lights;
    r.temp_drive = nx.temp;
    r.humid_drive = nx.humid;
    r.active_count = 2'(nx.lights) + 2'(nx.temp) + 2'(nx.humid);
    r.any_changed = (nx != relays);
    relays = nx;
    return r;
  endfunction

  function automatic crc_pkg::sample_t make_sample(int hour, int temp, int humid, logic fault);
    crc_pkg::sample_t s;
    s.hour_now = 5'(hour);
    s.temp_reading = 12'(temp);
    s.humid_reading = 10'(humid);
    s.sensor_fault = fault;
    return s;
  endfunction

  // mostly readings around the set points so the thermostats swing, some raw noise
  function automatic crc_pkg::sample_t pick_sample();
    crc_pkg::sample_t s;
    int tset, hset, tband, hband, temp, humid;
    tset = int'(shadow_cfg.temp_target) * 10;
    hset = int'(shadow_cfg.humid_target) * 10;
    tband = int'(shadow_cfg.temp_band);
    hband = int'(shadow_cfg.humid_band);
    s.hour_now = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(23));
    if ($urandom_range(4) == 0) begin
      s.temp_reading = 12'($urandom);
      s.humid_reading = 10'($urandom);
    end else begin
      temp = tset - tband - 15 + int'($urandom_range(2 * tband + 30));
      humid = hset - hband - 15 + int'($urandom_range(2 * hband + 30));
      if (humid < 0) humid = 0;
      if (humid > 1023) humid = 1023;
      s.temp_reading = 12'(temp);
      s.humid_reading = 10'(humid);
    end
    s.sensor_fault = ($urandom_range(11) == 0);
    return s;
  endfunction

  function automatic logic [9:0] pick_window();
    if ($urandom_range(7) == 0) return 10'($urandom);
    return {5'($urandom_range(24)), 5'($urandom_range(24))};
  endfunction

  function automatic logic [9:0] hours(int on_h, int off_h);
    return {5'(off_h), 5'(on_h)};
  endfunction

  function automatic logic [9:0] modes(logic t_thermo, logic t_cool, logic h_thermo,
                                       logic h_lower);
    logic [9:0] m;
    m = '0;
    m[crc_pkg::MODE_TEMP_THERMO] = t_thermo;
    m[crc_pkg::MODE_TEMP_COOL] = t_cool;
    m[crc_pkg::MODE_HUMID_THERMO] = h_thermo;
    m[crc_pkg::MODE_HUMID_LOWER] = h_lower;
    return m;
  endfunction

  function automatic logic idle_draw();
    return !calm && ($urandom_range(99) < 6);
  endfunction

  task automatic write_reg(input logic [crc_pkg::CfgIndexWidth-1:0] idx,
                           input logic [crc_pkg::CfgDataWidth-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      crc_pkg::REG_MODE_BITS:     shadow_cfg.mode_bits = val[3:0];
      crc_pkg::REG_LIGHTS_WINDOW: shadow_cfg.lights_window = val[9:0];
      crc_pkg::REG_TEMP_WINDOW:   shadow_cfg.temp_window = val[9:0];
      crc_pkg::REG_HUMID_WINDOW:  shadow_cfg.humid_window = val[9:0];
      crc_pkg::REG_TEMP_TARGET:   shadow_cfg.temp_target = val[5:0];
      crc_pkg::REG_HUMID_TARGET:  shadow_cfg.humid_target = val[6:0];
      crc_pkg::REG_TEMP_BAND:     shadow_cfg.temp_band = val[6:0];
      crc_pkg::REG_HUMID_BAND:    shadow_cfg.humid_band = val[7:0];
      default: ;
    endcase
  endtask

  // every register, then a write to an unused index that must change nothing
  task automatic load_settings(input logic [crc_pkg::CfgDataWidth-1:0] mode, lw, tw, hw, tt,
                               ht, tb, hb);
    write_reg(crc_pkg::REG_MODE_BITS, mode);
    write_reg(crc_pkg::REG_LIGHTS_WINDOW, lw);
    write_reg(crc_pkg::REG_TEMP_WINDOW, tw);
    write_reg(crc_pkg::REG_HUMID_WINDOW, hw);
    write_reg(crc_pkg::REG_TEMP_TARGET, tt);
    write_reg(crc_pkg::REG_HUMID_TARGET, ht);
    write_reg(crc_pkg::REG_TEMP_BAND, tb);
    write_reg(crc_pkg::REG_HUMID_BAND, hb);
    write_reg(REG_FIRST_UNUSED + 4'($urandom_range(7)), 10'($urandom));
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic drain();
    @(negedge clk);
    while (sample_queue.size() != 0 || sample_valid || status_due.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : sample_feed
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        status_due.push_back(next_status(sample));
        samples_taken++;
      end
      if (!sample_valid || !sample_stall) begin
        if (sample_queue.size() != 0 && !idle_draw()) begin
          sample <= sample_queue.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : status_check
    crc_pkg::status_t want;
    if (rst) begin
      status_stall <= 1'b0;
    end else begin
      if (status_valid && !status_stall) begin
        statuses_seen++;
        if (status_due.size() == 0) begin
          errors++;
          if (errors <= SHOW_LIMIT)
            $display("%0t: unexpected status beat %p", $time, status);
        end else begin
          want = status_due.pop_front();
          if (status.lights_drive !== want.lights_drive || status.temp_drive !== want.temp_drive ||
              status.humid_drive !== want.humid_drive ||
              status.active_count !== want.active_count ||
              status.any_changed !== want.any_changed) begin
            errors++;
            if (errors <= SHOW_LIMIT)
              $display("%0t: status mismatch, expected %p, actual %p", $time, want, status);
          end
        end
      end
      status_stall <= idle_draw();
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (sample_valid && !sample_stall) || (status_valid && !status_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d status beats outstanding", $time,
               WATCHDOG_LIMIT, status_due.size());
      $display("climate_relay_controller verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [crc_pkg::CfgDataWidth-1:0] mode, tt, ht, tb, hb;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset values, all relays timed with empty windows
    sample_queue.push_back(make_sample(0, 0, 0, 1'b0));
    sample_queue.push_back(make_sample(31, -2048, 1023, 1'b1));
    drain();

    // cooling and lowering, lights window wrapping past midnight
    load_settings(modes(1'b1, 1'b1, 1'b1, 1'b1), hours(22, 6), hours(0, 0), hours(0, 0),
                  10'd25, 10'd60, 10'd10, 10'd20);
    sample_queue.push_back(make_sample(22, 251, 621, 1'b0));
    sample_queue.push_back(make_sample(5, 245, 590, 1'b0));
    sample_queue.push_back(make_sample(6, 240, 579, 1'b0));
    sample_queue.push_back(make_sample(12, 300, 700, 1'b1));
    sample_queue.push_back(make_sample(23, 2047, 1023, 1'b0));
    drain();

    // heating and raising with bands of 100 and 200, lights window 0 to 24
    load_settings(modes(1'b1, 1'b0, 1'b1, 1'b0), hours(0, 24), hours(3, 9), hours(3, 9),
                  10'd0, 10'd100, 10'd100, 10'd200);
    sample_queue.push_back(make_sample(10, -1, 999, 1'b0));
    sample_queue.push_back(make_sample(11, 99, 1023, 1'b0));
    sample_queue.push_back(make_sample(12, 100, 500, 1'b0));
    sample_queue.push_back(make_sample(13, -400, 0, 1'b1));
    sample_queue.push_back(make_sample(14, -2048, 1000, 1'b0));
    drain();

    // timed mode: window 24 to 0, equal hours, hours beyond the day
    load_settings(modes(1'b0, 1'b0, 1'b0, 1'b0), hours(24, 0), hours(7, 7), hours(26, 30),
                  10'd0, 10'd0, 10'd0, 10'd0);
    sample_queue.push_back(make_sample(27, 0, 0, 1'b1));
    sample_queue.push_back(make_sample(7, 0, 0, 1'b0));
    sample_queue.push_back(make_sample(0, 0, 0, 1'b0));
    sample_queue.push_back(make_sample(31, 0, 0, 1'b0));
    sample_queue.push_back(make_sample(24, 0, 0, 1'b0));
    drain();

    // timed mode with fault present, raw register maxima
    load_settings(modes(1'b0, 1'b1, 1'b0, 1'b1), hours(31, 31), hours(20, 3), hours(0, 31),
                  10'd63, 10'd127, 10'd127, 10'd255);
    sample_queue.push_back(make_sample(25, 1000, 1000, 1'b1));
    sample_queue.push_back(make_sample(2, -1000, 10, 1'b1));
    sample_queue.push_back(make_sample(31, 5, 5, 1'b0));
    drain();

    for (int p = 0; p < 10; p++) begin
      calm = (p == 5);
      if (p == 0) begin
        load_settings(10'hF, 10'h3FF, 10'h3FF, 10'h3FF, 10'd63, 10'd127, 10'd127, 10'd255);
      end else if (p == 1) begin
        load_settings(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
      end else begin
        mode = 10'($urandom_range(15));
        tt = ($urandom_range(4) == 0) ? 10'($urandom_range(63)) : 10'($urandom_range(40));
        ht = ($urandom_range(4) == 0) ? 10'($urandom_range(127)) : 10'($urandom_range(100));
        tb = ($urandom_range(4) == 0) ? 10'($urandom_range(127)) : 10'($urandom_range(100));
        hb = ($urandom_range(4) == 0) ? 10'($urandom_range(255)) : 10'($urandom_range(200));
        load_settings(mode, pick_window(), pick_window(), pick_window(), tt, ht, tb, hb);
      end
      repeat (55) sample_queue.push_back(pick_sample());
      drain();
    end

    $display("%0d samples driven and %0d status beats checked over %0d register settings",
             samples_taken, statuses_seen, settings_loaded);
    $display("%0d mismatching or unexpected status beats", errors);
    if (errors == 0 && status_due.size() == 0) begin
      $display("climate_relay_controller verification clean");
    end else begin
      $display("climate_relay_controller verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/crc_pkg.sv
sv/crc_cfg_regs.sv
sv/crc_relay_logic.sv
sv/climate_relay_controller.sv
tb/sv/climate_relay_controller_tb.sv
